@@ sv/range_min_segment_tree_assert.svh @@
// assertion macros for the range minimum segment tree
`ifndef RANGE_MIN_SEGMENT_TREE_ASSERT_SVH
`define RANGE_MIN_SEGMENT_TREE_ASSERT_SVH

// property that must hold every cycle outside reset
`define RMST_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("rmst check failed");

// implication whose consequent is checked in the cycle after the antecedent
`define RMST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rmst check failed");

`endif

@@ sv/rmst_pkg.sv @@
// ----------------------------------------------------------------------------
// rmst_pkg
// shared types and constants of the range minimum segment tree
// ----------------------------------------------------------------------------
package rmst_pkg;
  localparam int unsigned Leaves = 1024;
  localparam int unsigned LeafW = $clog2(Leaves);
  localparam int unsigned NodeW = LeafW + 1;
  localparam int unsigned Depth = 2 * Leaves;
  localparam int unsigned ValW = 32;
  localparam int unsigned PosW = 10;
  localparam logic [ValW-1:0] AllOnes = '1;
  localparam int unsigned QDepth = 2;

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_QUERY  = 1'b1
  } op_e;

  typedef struct packed {
    op_e             op;
    logic            skip;
    logic [LeafW-1:0] lo;
    logic [LeafW-1:0] hi;
    logic [ValW-1:0]  val;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_UPD_RD,
    ST_UPD_WAIT,
    ST_UPD_WR,
    ST_Q_STEP,
    ST_Q_WAIT,
    ST_OUT
  } state_e;
endpackage

@@ sv/rmst_ram.sv @@
// ----------------------------------------------------------------------------
// rmst_ram
// generic single write, dual read ram with registered read data
// ----------------------------------------------------------------------------
module rmst_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end
endmodule

@@ sv/rmst_front.sv @@
// ----------------------------------------------------------------------------
// rmst_front
// accepts transactions, classifies them and queues commands
// ----------------------------------------------------------------------------
module rmst_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_tvalid_i,
  output logic                     s_tready_o,
  input  logic [55:0]              s_tdata_i,
  output logic                     cmd_valid_o,
  input  logic                     cmd_ready_i,
  output rmst_pkg::cmd_t           cmd_o
);
  import rmst_pkg::*;

  cmd_t            q_mem [QDepth];
  logic            wp_q, rp_q;
  logic [1:0]      cnt_q;
  cmd_t            c;
  logic [PosW-1:0] lo, hi;
  logic            push, pop;

  assign lo = s_tdata_i[10:1];
  assign hi = s_tdata_i[20:11];

  always_comb begin
    c.op   = op_e'(s_tdata_i[0]);
    c.lo   = lo[LeafW-1:0];
    c.hi   = hi[LeafW-1:0];
    c.val  = s_tdata_i[52:21];
    if (c.op == OP_UPDATE) begin
      c.skip = ({22'd0, lo} >= Leaves);
    end else begin
      c.skip = (lo > hi) || ({22'd0, hi} >= Leaves);
    end
  end

  assign s_tready_o  = (cnt_q != 2'(QDepth));
  assign push        = s_tvalid_i && s_tready_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = q_mem[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wp_q] <= c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end
endmodule

@@ sv/rmst_back.sv @@
// ----------------------------------------------------------------------------
// rmst_back
// walks the tree for updates and queries over the node ram
// ----------------------------------------------------------------------------
`include "range_min_segment_tree_assert.svh"
module rmst_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cmd_valid_i,
  output logic                      cmd_ready_o,
  input  rmst_pkg::cmd_t            cmd_i,
  output logic                      m_tvalid_o,
  input  logic                      m_tready_i,
  output logic [rmst_pkg::ValW-1:0] m_tdata_o
);
  import rmst_pkg::*;

  state_e           st_q, st_d;
  logic [NodeW-1:0] l_q, l_d, r_q, r_d, clr_q, clr_d;
  logic [ValW-1:0]  acc_q, acc_d, val_q, val_d;
  logic             take_l_q, take_l_d, take_r_q, take_r_d;
  logic             we;
  logic [NodeW-1:0] waddr, ra, rb;
  logic [ValW-1:0]  wdata, rda, rdb, m;

  rmst_ram #(.Width(ValW), .Depth(Depth)) u_ram (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr_a_i(ra),
    .raddr_b_i(rb),
    .rdata_a_o(rda),
    .rdata_b_o(rdb)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_CLEAR;
      clr_q    <= '0;
      l_q      <= '0;
      r_q      <= '0;
      acc_q    <= AllOnes;
      val_q    <= '0;
      take_l_q <= 1'b0;
      take_r_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      clr_q    <= clr_d;
      l_q      <= l_d;
      r_q      <= r_d;
      acc_q    <= acc_d;
      val_q    <= val_d;
      take_l_q <= take_l_d;
      take_r_q <= take_r_d;
    end
  end

  always_comb begin
    st_d        = st_q;
    clr_d       = clr_q;
    l_d         = l_q;
    r_d         = r_q;
    acc_d       = acc_q;
    val_d       = val_q;
    take_l_d    = take_l_q;
    take_r_d    = take_r_q;
    we          = 1'b0;
    waddr       = l_q;
    wdata       = val_q;
    ra          = {l_q[NodeW-2:0], 1'b0};
    rb          = {l_q[NodeW-2:0], 1'b1};
    cmd_ready_o = 1'b0;
    m           = (rda < rdb) ? rda : rdb;
    case (st_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = AllOnes;
        clr_d = clr_q + NodeW'(1);
        if (clr_q == NodeW'(Depth - 1)) st_d = ST_IDLE;
      end
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          acc_d = AllOnes;
          l_d   = {1'b1, cmd_i.lo};
          r_d   = {1'b1, cmd_i.hi};
          val_d = cmd_i.val;
          if (cmd_i.op == OP_QUERY) begin
            st_d = cmd_i.skip ? ST_OUT : ST_Q_STEP;
          end else if (!cmd_i.skip) begin
            st_d = ST_UPD_WR;
          end
        end
      end
      ST_UPD_WR: begin
        // write leaf or recomputed ancestor, then move up
        we = 1'b1;
        if (l_q == NodeW'(1)) begin
          st_d = ST_IDLE;
        end else begin
          l_d  = l_q >> 1;
          st_d = ST_UPD_RD;
        end
      end
      ST_UPD_RD: begin
        st_d = ST_UPD_WAIT;
      end
      ST_UPD_WAIT: begin
        val_d = m;
        st_d  = ST_UPD_WR;
      end
      ST_Q_STEP: begin
        ra = l_q;
        rb = r_q;
        if (l_q > r_q) begin
          st_d = ST_OUT;
        end else begin
          take_l_d = l_q[0];
          take_r_d = !r_q[0];
          // one extra bit so the last leaf steps past the end
          l_d = NodeW'(({1'b0, l_q} + {{NodeW{1'b0}}, l_q[0]}) >> 1);
          r_d = (r_q - NodeW'(!r_q[0])) >> 1;
          st_d = ST_Q_WAIT;
        end
      end
      ST_Q_WAIT: begin
        if (take_l_q && rda < acc_d) acc_d = rda;
        if (take_r_q && rdb < acc_d) acc_d = rdb;
        st_d = ST_Q_STEP;
      end
      ST_OUT: begin
        if (m_tready_i) st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  assign m_tvalid_o = (st_q == ST_OUT);
  assign m_tdata_o  = acc_q;

  `RMST_ASSERT(a_no_ready_busy, !(cmd_ready_o && st_q != ST_IDLE))
  `RMST_ASSERT_NEXT(a_out_hold, m_tvalid_o && !m_tready_i, m_tvalid_o && $stable(acc_q))
  `RMST_ASSERT(a_no_write_query, !(we && (st_q == ST_Q_STEP || st_q == ST_Q_WAIT)))
endmodule

@@ sv/range_min_segment_tree.sv @@
// ----------------------------------------------------------------------------
// range_min_segment_tree
// range minimum segment tree with point updates over a node ram
// ----------------------------------------------------------------------------
// update writes the leaf, then per ancestor passes the read, wait and write
// states up to the root; query passes step and wait states per tree level;
// one item at a time in the walker, paced by the dual read node ram walk
// reset: async active low; a clearing pass writes all 2048 ram words
// with all-ones before any transaction is taken by the walker
module range_min_segment_tree (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [55:0] s_tdata_i,  // opcode, index_or_low, range_high, new_value
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [31:0] m_tdata_o   // minimum
);
  import rmst_pkg::*;

  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  rmst_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .cmd_valid_o(cmd_valid),
    .cmd_ready_i(cmd_ready),
    .cmd_o      (cmd)
  );

  rmst_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_ready_o(cmd_ready),
    .cmd_i      (cmd),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );
endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// random and directed test of the range minimum segment tree: a local array
// model of the leaves predicts each query minimum, the monitor compares every
// result transaction in order with the predicted queue
// ----------------------------------------------------------------------------
module tb_top;
  import rmst_pkg::*;

  typedef struct packed {
    op_e              op;
    logic [PosW-1:0]  lo;
    logic [PosW-1:0]  hi;
    logic [ValW-1:0]  val;
  } item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid_i = 1'b0;
  logic        s_tready_o;
  logic [55:0] s_tdata_i = '0;
  logic        m_tvalid_o;
  logic        m_tready_i = 1'b0;
  logic [31:0] m_tdata_o;

  item_t           pending_q[$];
  logic [ValW-1:0] minimum_q[$];
  logic [ValW-1:0] leaf_val[Leaves];
  int              errors = 0;
  int              burst_left = 0;
  int              gap_left = 0;
  int              stall_phase = 0;
  logic            hold_off = 1'b0;
  item_t           cur;

  range_min_segment_tree dut (.*);

  always #4 clk_i = ~clk_i;

  // pack: opcode lowest, then index_or_low, range_high, new_value
  function automatic logic [55:0] pack_item(item_t it);
    return {3'b0, it.val, it.hi, it.lo, it.op};
  endfunction

  function automatic logic [ValW-1:0] range_minimum(int lo, int hi);
    logic [ValW-1:0] m;
    m = AllOnes;
    if (lo > hi || hi >= Leaves) return AllOnes;
    for (int i = lo; i <= hi; i++) if (leaf_val[i] < m) m = leaf_val[i];
    return m;
  endfunction

  task automatic add_item(op_e op, int lo, int hi, logic [ValW-1:0] val);
    item_t it;
    it.op = op;
    it.lo = lo[PosW-1:0];
    it.hi = hi[PosW-1:0];
    it.val = val;
    pending_q.push_back(it);
  endtask

  // driver
  always @(posedge clk_i) begin
    if (s_tvalid_i && s_tready_o) begin
      if (cur.op == OP_UPDATE) begin
        leaf_val[cur.lo] <= cur.val;
      end else begin
        minimum_q.push_back(range_minimum(cur.lo, cur.hi));
      end
    end
    if (!s_tvalid_i || s_tready_o) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_tvalid_i <= 1'b0;
      end else if (pending_q.size() > 0 && rst_ni && !hold_off) begin
        cur = pending_q.pop_front();
        s_tdata_i <= pack_item(cur);
        s_tvalid_i <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 30);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_tvalid_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    logic [ValW-1:0] exp_min;
    stall_phase <= stall_phase + 1;
    m_tready_i <= (stall_phase % 300 < 100) ? 1'b1 : ($urandom_range(0, 2) != 0);
    if (m_tvalid_o && m_tready_i) begin
      if (minimum_q.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h", $time, m_tdata_o);
        errors++;
      end else begin
        exp_min = minimum_q.pop_front();
        if (m_tdata_o !== exp_min) begin
          $display("%0t minimum mismatch: expected %h actual %h", $time, exp_min,
                   m_tdata_o);
          errors++;
        end
      end
    end
  end

  initial begin
    int lo;
    int hi;
    for (int i = 0; i < Leaves; i++) leaf_val[i] = AllOnes;
    // directed part
    add_item(OP_QUERY, 0, Leaves - 1, 0);
    add_item(OP_UPDATE, 0, 0, 32'h0);
    add_item(OP_UPDATE, Leaves - 1, 0, 32'hffff_ffff);
    add_item(OP_UPDATE, 511, 0, 32'h5555_aaaa);
    add_item(OP_UPDATE, 512, 0, 32'haaaa_5555);
    add_item(OP_QUERY, 0, 0, 0);
    add_item(OP_QUERY, 1, Leaves - 1, 0);
    add_item(OP_QUERY, 511, 512, 0);
    add_item(OP_QUERY, 512, 511, 0);
    add_item(OP_QUERY, Leaves - 1, Leaves - 1, 32'hffff_ffff);
    add_item(OP_QUERY, 0, Leaves - 1, 0);
    add_item(OP_UPDATE, 0, 1023, 32'h7fff_ffff);
    add_item(OP_QUERY, 0, 1, 0);
    add_item(OP_QUERY, 0, Leaves - 1, 0);
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    // random part, mostly updates and queries over small ranges
    for (int n = 0; n < 800; n++) begin
      if (n == 400) begin
        wait (pending_q.size() == 0);
        hold_off <= 1'b1;
        wait (!s_tvalid_i && minimum_q.size() == 0);
        @(posedge clk_i);
        hold_off <= 1'b0;
      end
      lo = $urandom_range(0, Leaves - 1);
      hi = ($urandom_range(0, 3) == 0) ? $urandom_range(0, Leaves - 1)
                                       : lo + $urandom_range(0, 40);
      if (hi > Leaves - 1) hi = Leaves - 1;
      if ($urandom_range(0, 1) == 0) begin
        add_item(OP_UPDATE, lo, $urandom, ($urandom_range(0, 3) == 0) ?
                 $urandom_range(0, 255) : $urandom);
      end else begin
        add_item(OP_QUERY, lo, hi, $urandom);
      end
    end
    wait (pending_q.size() == 0);
    @(posedge clk_i);
    wait (!s_tvalid_i && minimum_q.size() == 0);
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end
endmodule
